// ===== design/beacon_parser_network_table_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the beacon parser network table
// Implication checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef BEACON_PARSER_NETWORK_TABLE_ASSERT_SVH
`define BEACON_PARSER_NETWORK_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define BPNT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BPNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPNT_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BPNT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/bpnt_pkg.sv =====
// ----------------------------------------------------------------------------
// bpnt_pkg
// Shared constants and types of the beacon parser network table.
// ----------------------------------------------------------------------------
package bpnt_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
    localparam int NAME_BYTES    = 32;
    localparam int NAME_W        = $clog2(NAME_BYTES);
    localparam int POS_W         = 17;

    // opcodes
    localparam logic [1:0] OP_BYTE  = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_ENTRY = 2'd2;
    localparam logic [1:0] OP_SSID  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_FRAME = 2'd0;
    localparam logic [1:0] KIND_CLEAR = 2'd1;
    localparam logic [1:0] KIND_ENTRY = 2'd2;
    localparam logic [1:0] KIND_SSID  = 2'd3;

    // frame verdicts
    localparam logic [2:0] ST_NEW     = 3'd0;
    localparam logic [2:0] ST_UPDATED = 3'd1;
    localparam logic [2:0] ST_BAD     = 3'd2;
    localparam logic [2:0] ST_NOT_BCN = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    // security codes
    localparam logic [1:0] SEC_PRIVACY = 2'd1;
    localparam logic [1:0] SEC_RSN     = 2'd2;

    // element ids and frame constants
    localparam logic [7:0]  EID_SSID     = 8'd0;
    localparam logic [7:0]  EID_DS       = 8'd3;
    localparam logic [7:0]  EID_RSN      = 8'd48;
    localparam logic [7:0]  MIN_HOFF     = 8'h4C;
    localparam logic [7:0]  FTYPE_MASK   = 8'hFC;
    localparam logic [7:0]  FTYPE_BEACON = 8'h80;
    localparam logic [7:0]  FTYPE_PROBE  = 8'h50;
    localparam logic [15:0] MIN_MLEN     = 16'd36;
    localparam logic [7:0]  LEVEL_BIAS   = 8'd100;
    localparam logic [7:0]  LEVEL_SAT    = 8'd227;

    typedef struct packed {
        logic [47:0]       bssid;
        logic [7:0]        channel;
        logic signed [7:0] rssi;
        logic [1:0]        security;
        logic [5:0]        ssid_length;
    } bpnt_entry_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } bpnt_token_t;

    // table write broadcast; entry.rssi carries the new level
    typedef struct packed {
        logic              en;
        logic              is_new;
        logic [SLOT_W-1:0] slot;
        bpnt_entry_t       entry;
    } bpnt_wr_t;

    // parsed view of the current buffer
    typedef struct packed {
        logic [POS_W-1:0] size;
        logic [7:0]       hoff;
        logic [8:0]       doff;
        logic [7:0]       hlen;
        logic [15:0]      mlen;
        logic [7:0]       level_raw;
        logic [7:0]       frame_ctl;
        logic [47:0]      bssid;
        logic [7:0]       channel;
        logic [1:0]       security;
        logic [5:0]       name_len;
    } bpnt_frame_t;

endpackage

// ===== design/bpnt_if.sv =====
// ----------------------------------------------------------------------------
// bpnt request and response channels
// Valid/ready channels carrying one item each.
// ----------------------------------------------------------------------------
interface bpnt_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [4:0] entry_index;
    logic [4:0] byte_index;

    modport source (output valid, opcode, data_byte, last_byte, entry_index, byte_index,
                    input ready);
    modport sink   (input valid, opcode, data_byte, last_byte, entry_index, byte_index,
                    output ready);
endinterface

interface bpnt_rsp_if;
    logic              valid;
    logic              ready;
    logic [1:0]        result_kind;
    logic [2:0]        frame_status;
    logic [4:0]        slot_index;
    logic [47:0]       bssid;
    logic [7:0]        channel;
    logic signed [7:0] rssi;
    logic [1:0]        security;
    logic [5:0]        ssid_length;
    logic [7:0]        ssid_byte;
    logic [5:0]        network_count;
    logic [31:0]       frame_count;

    modport source (output valid, result_kind, frame_status, slot_index, bssid, channel,
                    rssi, security, ssid_length, ssid_byte, network_count, frame_count,
                    input ready);
    modport sink   (input valid, result_kind, frame_status, slot_index, bssid, channel,
                    rssi, security, ssid_length, ssid_byte, network_count, frame_count,
                    output ready);
endinterface

// ===== design/bpnt_parser.sv =====
// ----------------------------------------------------------------------------
// bpnt_parser
// Captures descriptor words and frame fields, walks information elements.
// ----------------------------------------------------------------------------
module bpnt_parser
    import bpnt_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       restart,
    input  logic                       byte_en,
    input  logic [7:0]                 data_byte,
    output bpnt_frame_t                frame,
    output logic [NAME_BYTES-1:0][7:0] name
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [31:0] w0_reg, w0_next, w3_reg, w3_next, w4_reg, w4_next, w7_reg, w7_next;
    logic [7:0]  fc_reg, fc_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  eid_reg, eid_next;
    logic [7:0]  elen_reg, elen_next;
    logic [7:0]  ecnt_reg, ecnt_next;
    logic        stop_reg, stop_next;
    logic [47:0] bssid_reg, bssid_next;
    logic [NAME_BYTES-1:0][7:0] name_reg, name_next;
    logic [5:0]  nlen_reg, nlen_next;
    logic [7:0]  chan_reg, chan_next;
    logic [1:0]  sec_reg, sec_next;

    logic [7:0]       hoff;
    logic [15:0]      mlen;
    logic [POS_W-1:0] rel;
    logic [31:0]      w0_shift;
    logic             in_frame;

    localparam logic [1:0] PH_ID   = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    assign hoff     = w3_reg[23:16];
    assign mlen     = w4_reg[31:16];
    assign rel      = pos_reg - {{(POS_W-8){1'b0}}, hoff};
    assign w0_shift = {w0_reg[23:0], data_byte};
    assign in_frame = (pos_reg >= POS_W'(32)) && (hoff >= MIN_HOFF)
                      && (pos_reg >= {{(POS_W-8){1'b0}}, hoff})
                      && (rel < {{(POS_W-16){1'b0}}, mlen});

    // per-byte capture and element walk
    always_comb
    begin
        pos_next   = pos_reg;
        w0_next    = w0_reg;
        w3_next    = w3_reg;
        w4_next    = w4_reg;
        w7_next    = w7_reg;
        fc_next    = fc_reg;
        phase_next = phase_reg;
        eid_next   = eid_reg;
        elen_next  = elen_reg;
        ecnt_next  = ecnt_reg;
        stop_next  = stop_reg;
        bssid_next = bssid_reg;
        name_next  = name_reg;
        nlen_next  = nlen_reg;
        chan_next  = chan_reg;
        sec_next   = sec_reg;
        if (restart)
        begin
            pos_next   = '0;
            w0_next    = '0;
            w3_next    = '0;
            w4_next    = '0;
            w7_next    = '0;
            fc_next    = '0;
            phase_next = PH_ID;
            eid_next   = '0;
            elen_next  = '0;
            ecnt_next  = '0;
            stop_next  = 1'b0;
            bssid_next = '0;
            name_next  = '0;
            nlen_next  = '0;
            chan_next  = '0;
            sec_next   = '0;
        end
        else if (byte_en)
        begin
            if (pos_reg != {POS_W{1'b1}})
                pos_next = pos_reg + POS_W'(1);
            if (pos_reg < POS_W'(32))
            begin
                case (pos_reg[4:2])
                    3'd0: w0_next = w0_shift;
                    3'd3: w3_next = {w3_reg[23:0], data_byte};
                    3'd4: w4_next = {w4_reg[23:0], data_byte};
                    3'd7: w7_next = {w7_reg[23:0], data_byte};
                    default: ;
                endcase
                if (pos_reg == POS_W'(3))
                    chan_next = {3'b000, w0_shift[11], w0_shift[16:13]};
            end
            else if (in_frame)
            begin
                if (rel == '0)
                    fc_next = data_byte;
                if (rel >= POS_W'(16) && rel < POS_W'(22))
                begin
                    case (rel[2:0])
                        3'd0: bssid_next[7:0]   = data_byte;
                        3'd1: bssid_next[15:8]  = data_byte;
                        3'd2: bssid_next[23:16] = data_byte;
                        3'd3: bssid_next[31:24] = data_byte;
                        3'd4: bssid_next[39:32] = data_byte;
                        3'd5: bssid_next[47:40] = data_byte;
                        default: ;
                    endcase
                end
                else if (rel == POS_W'(34))
                begin
                    if (data_byte[4])
                        sec_next = SEC_PRIVACY;
                end
                else if (rel >= POS_W'(36) && !stop_reg)
                begin
                    case (phase_reg)
                        PH_ID:
                        begin
                            if ({1'b0, rel} + 18'd2 > {2'b00, mlen})
                                stop_next = 1'b1;
                            else
                            begin
                                eid_next   = data_byte;
                                phase_next = PH_LEN;
                            end
                        end
                        PH_LEN:
                        begin
                            elen_next = data_byte;
                            ecnt_next = '0;
                            if ({1'b0, rel} + 18'd1 + {10'd0, data_byte} > {2'b00, mlen})
                                stop_next = 1'b1;
                            else
                            begin
                                if (eid_reg == EID_SSID && data_byte <= 8'd32)
                                    nlen_next = data_byte[5:0];
                                else if (eid_reg == EID_RSN)
                                    sec_next = SEC_RSN;
                                phase_next = (data_byte != 8'd0) ? PH_BODY : PH_ID;
                            end
                        end
                        default:
                        begin
                            if (eid_reg == EID_SSID && elen_reg <= 8'd32)
                                name_next[ecnt_reg[NAME_W-1:0]] = data_byte;
                            else if (eid_reg == EID_DS && ecnt_reg == 8'd0)
                                chan_next = data_byte;
                            ecnt_next = ecnt_reg + 8'd1;
                            if ({1'b0, ecnt_reg} + 9'd1 >= {1'b0, elen_reg})
                                phase_next = PH_ID;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            w0_reg    <= '0;
            w3_reg    <= '0;
            w4_reg    <= '0;
            w7_reg    <= '0;
            fc_reg    <= '0;
            phase_reg <= PH_ID;
            eid_reg   <= '0;
            elen_reg  <= '0;
            ecnt_reg  <= '0;
            stop_reg  <= 1'b0;
            bssid_reg <= '0;
            name_reg  <= '0;
            nlen_reg  <= '0;
            chan_reg  <= '0;
            sec_reg   <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            w0_reg    <= w0_next;
            w3_reg    <= w3_next;
            w4_reg    <= w4_next;
            w7_reg    <= w7_next;
            fc_reg    <= fc_next;
            phase_reg <= phase_next;
            eid_reg   <= eid_next;
            elen_reg  <= elen_next;
            ecnt_reg  <= ecnt_next;
            stop_reg  <= stop_next;
            bssid_reg <= bssid_next;
            name_reg  <= name_next;
            nlen_reg  <= nlen_next;
            chan_reg  <= chan_next;
            sec_reg   <= sec_next;
        end
    end

    assign frame.size      = pos_reg;
    assign frame.hoff      = hoff;
    assign frame.doff      = w3_reg[15:7];
    assign frame.hlen      = w3_reg[31:24];
    assign frame.mlen      = mlen;
    assign frame.level_raw = w7_reg[31:24];
    assign frame.frame_ctl = fc_reg;
    assign frame.bssid     = bssid_reg;
    assign frame.channel   = chan_reg;
    assign frame.security  = sec_reg;
    assign frame.name_len  = nlen_reg;
    assign name            = name_reg;

endmodule

// ===== design/bpnt_cell.sv =====
// ----------------------------------------------------------------------------
// bpnt_cell
// One table entry; compares the passing search token against its BSSID.
// ----------------------------------------------------------------------------
module bpnt_cell
    import bpnt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] cell_index,
    input  logic [SLOT_W:0]   used_count,
    input  logic [47:0]       key,
    input  bpnt_token_t       tok_in,
    input  bpnt_wr_t          wr,
    output bpnt_token_t       tok_out,
    output bpnt_entry_t       entry
);

    bpnt_token_t tok_reg, tok_next;
    bpnt_entry_t entry_reg, entry_next;
    logic        live;

    assign live = {1'b0, cell_index} < used_count;

    // token hop: first live match claims the slot
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.found && live && entry_reg.bssid == key)
        begin
            tok_next.found = 1'b1;
            tok_next.slot  = cell_index;
        end
    end

    // entry write, keeping the best level on update
    always_comb
    begin
        entry_next = entry_reg;
        if (wr.en && wr.slot == cell_index)
        begin
            entry_next.channel     = wr.entry.channel;
            entry_next.security    = wr.entry.security;
            entry_next.ssid_length = wr.entry.ssid_length;
            if (wr.is_new)
            begin
                entry_next.bssid = wr.entry.bssid;
                entry_next.rssi  = wr.entry.rssi;
            end
            else if (wr.entry.rssi > entry_reg.rssi)
                entry_next.rssi = wr.entry.rssi;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign tok_out = tok_reg;
    assign entry   = entry_reg;

endmodule

// ===== design/beacon_parser_network_table.sv =====
// ----------------------------------------------------------------------------
// beacon_parser_network_table
// Beacon / probe response parser with a 32-entry network table.
// ----------------------------------------------------------------------------
//  channel | dir | item
//  req     | in  | opcode, data_byte, last_byte, entry_index, byte_index
//  rsp     | out | verdict, clear ack, entry data or SSID byte
//
//  Buffer bytes, clears and entry reads are handled in idle; SSID reads
//  add a name memory read step. A last byte that stores an entry goes
//  through accept, verdict, a BSSID search down the cell chain, a write
//  step, an SSID copy into name memory and the result step. A rejected
//  buffer goes from verdict to result; table full follows the search.
//  Reset is asynchronous; no clearing pass is needed.
//  Requests wait while a result is held and not taken.
// ----------------------------------------------------------------------------
module beacon_parser_network_table
    import bpnt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    bpnt_req_if.sink   req,
    bpnt_rsp_if.source rsp
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_FINISH = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_COPY   = 3'd4;
    localparam logic [2:0] S_RESP   = 3'd5;
    localparam logic [2:0] S_READ   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [SLOT_W:0]   used_reg, used_next;
    logic [31:0]       frames_reg, frames_next;
    logic [2:0]        status_reg, status_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic signed [7:0] lvl_reg, lvl_next;
    logic [NAME_W-1:0] copy_reg, copy_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [SLOT_W-1:0] rd_slot_reg, rd_slot_next;

    // response register
    logic              ov_reg, ov_next;
    logic [1:0]        o_kind_reg, o_kind_next;
    logic [2:0]        o_status_reg, o_status_next;
    logic [SLOT_W-1:0] o_slot_reg, o_slot_next;
    bpnt_entry_t       o_entry_reg, o_entry_next;
    logic [7:0]        o_sbyte_reg, o_sbyte_next;
    logic [SLOT_W:0]   o_count_reg, o_count_next;
    logic [31:0]       o_frames_reg, o_frames_next;
    logic              o_use_rd;

    logic accept, out_free;

    // parser
    bpnt_frame_t                frame;
    logic [NAME_BYTES-1:0][7:0] name;
    logic                       p_restart, p_byte;

    // cell chain
    bpnt_token_t tok [TABLE_ENTRIES+1];
    bpnt_entry_t cell_entry [TABLE_ENTRIES];
    bpnt_wr_t    wr;
    logic        launch;

    // name memory
    logic [7:0]               name_mem [TABLE_ENTRIES*NAME_BYTES];
    logic                     mem_we;
    logic [SLOT_W+NAME_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]               mem_rdata;

    // verdict checks
    logic              bad, beacon;
    logic [7:0]        ftype;
    logic signed [7:0] lvl;
    bpnt_entry_t       sel_entry, rd_entry;

    assign out_free  = !ov_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    bpnt_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .restart   (p_restart),
        .byte_en   (p_byte),
        .data_byte (req.data_byte),
        .frame     (frame),
        .name      (name)
    );

    assign tok[0] = '{valid: launch, found: 1'b0, slot: '0};

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        bpnt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_index (SLOT_W'(i)),
            .used_count (used_reg),
            .key        (frame.bssid),
            .tok_in     (tok[i]),
            .wr         (wr),
            .tok_out    (tok[i+1]),
            .entry      (cell_entry[i])
        );
    end

    // descriptor and type checks on the finished buffer
    assign ftype = frame.frame_ctl & FTYPE_MASK;
    assign bad   = (frame.doff <= {1'b0, frame.hoff}) || (frame.mlen < {8'd0, frame.hlen})
                   || (frame.hoff < MIN_HOFF)
                   || ({{(POS_W-8){1'b0}}, frame.hoff} + {{(POS_W-16){1'b0}}, frame.mlen}
                       > frame.size)
                   || (frame.mlen < MIN_MLEN);
    assign beacon = (ftype == FTYPE_BEACON) || (ftype == FTYPE_PROBE);
    assign lvl    = (frame.level_raw > LEVEL_SAT) ? 8'sd127
                                                  : signed'(frame.level_raw - LEVEL_BIAS);

    // entry views for reads
    assign sel_entry = cell_entry[slot_reg];
    always_comb
    begin
        rd_entry = '0;
        if ({1'b0, req.entry_index} < used_reg)
            rd_entry = cell_entry[req.entry_index];
    end

    assign wr.en                = (state_reg == S_UPDATE);
    assign wr.is_new            = (status_reg == ST_NEW);
    assign wr.slot              = slot_reg;
    assign wr.entry.bssid       = frame.bssid;
    assign wr.entry.channel     = frame.channel;
    assign wr.entry.rssi        = lvl_reg;
    assign wr.entry.security    = frame.security;
    assign wr.entry.ssid_length = frame.name_len;

    assign mem_we    = (state_reg == S_COPY);
    assign mem_waddr = {slot_reg, copy_reg};
    assign mem_raddr = {req.entry_index, req.byte_index};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            name_mem[mem_waddr] <= name[copy_reg];
        mem_rdata <= name_mem[mem_raddr];
    end

    // control sequencer
    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        frames_next   = frames_reg;
        status_next   = status_reg;
        slot_next     = slot_reg;
        lvl_next      = lvl_reg;
        copy_next     = copy_reg;
        rd_ok_next    = rd_ok_reg;
        rd_slot_next  = rd_slot_reg;
        ov_next       = ov_reg && !rsp.ready;
        o_kind_next   = o_kind_reg;
        o_status_next = o_status_reg;
        o_slot_next   = o_slot_reg;
        o_entry_next  = o_entry_reg;
        o_sbyte_next  = o_sbyte_reg;
        o_count_next  = o_count_reg;
        o_frames_next = o_frames_reg;
        o_use_rd      = 1'b0;
        p_restart     = 1'b0;
        p_byte        = 1'b0;
        launch        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.opcode)
                        OP_BYTE:
                        begin
                            p_byte = 1'b1;
                            if (req.last_byte)
                                state_next = S_FINISH;
                        end
                        OP_CLEAR:
                        begin
                            p_restart     = 1'b1;
                            used_next     = '0;
                            frames_next   = '0;
                            ov_next       = 1'b1;
                            o_kind_next   = KIND_CLEAR;
                            o_status_next = ST_NEW;
                            o_slot_next   = '0;
                            o_entry_next  = '0;
                            o_sbyte_next  = '0;
                            o_count_next  = '0;
                            o_frames_next = '0;
                        end
                        OP_ENTRY:
                        begin
                            ov_next       = 1'b1;
                            o_kind_next   = KIND_ENTRY;
                            o_status_next = ST_NEW;
                            o_slot_next   = req.entry_index;
                            o_entry_next  = rd_entry;
                            o_sbyte_next  = '0;
                            o_count_next  = used_reg;
                            o_frames_next = frames_reg;
                        end
                        default:
                        begin
                            rd_slot_next = req.entry_index;
                            rd_ok_next   = ({1'b0, req.entry_index} < used_reg)
                                           && ({1'b0, req.byte_index} < rd_entry.ssid_length);
                            o_entry_next = rd_entry;
                            state_next   = S_READ;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                o_use_rd      = 1'b1;
                ov_next       = 1'b1;
                o_kind_next   = KIND_SSID;
                o_status_next = ST_NEW;
                o_slot_next   = rd_slot_reg;
                o_sbyte_next  = rd_ok_reg ? mem_rdata : 8'd0;
                o_count_next  = used_reg;
                o_frames_next = frames_reg;
                state_next    = S_IDLE;
            end
            S_FINISH:
            begin
                frames_next = frames_reg + 32'd1;
                if (bad)
                begin
                    status_next = ST_BAD;
                    state_next  = S_RESP;
                end
                else if (!beacon)
                begin
                    status_next = ST_NOT_BCN;
                    state_next  = S_RESP;
                end
                else
                begin
                    lvl_next   = lvl;
                    launch     = 1'b1;
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (tok[TABLE_ENTRIES].valid)
                begin
                    if (tok[TABLE_ENTRIES].found)
                    begin
                        slot_next   = tok[TABLE_ENTRIES].slot;
                        status_next = ST_UPDATED;
                        state_next  = S_UPDATE;
                    end
                    else if (used_reg >= (SLOT_W+1)'(TABLE_ENTRIES))
                    begin
                        status_next = ST_FULL;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        slot_next   = used_reg[SLOT_W-1:0];
                        used_next   = used_reg + (SLOT_W+1)'(1);
                        status_next = ST_NEW;
                        state_next  = S_UPDATE;
                    end
                end
            end
            S_UPDATE:
            begin
                copy_next  = '0;
                state_next = S_COPY;
            end
            S_COPY:
            begin
                copy_next = copy_reg + NAME_W'(1);
                if (copy_reg == {NAME_W{1'b1}})
                    state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_kind_next   = KIND_FRAME;
                    o_status_next = status_reg;
                    o_sbyte_next  = '0;
                    o_count_next  = used_reg;
                    o_frames_next = frames_reg;
                    if (status_reg == ST_NEW || status_reg == ST_UPDATED)
                    begin
                        o_slot_next  = slot_reg;
                        o_entry_next = sel_entry;
                    end
                    else
                    begin
                        o_slot_next  = '0;
                        o_entry_next = '0;
                    end
                    p_restart  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
        if (o_use_rd && !rd_ok_reg && rd_slot_reg >= used_reg[SLOT_W-1:0] && used_reg[SLOT_W])
            o_entry_next = o_entry_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            frames_reg <= '0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            frames_reg <= frames_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        lvl_reg      <= lvl_next;
        copy_reg     <= copy_next;
        rd_ok_reg    <= rd_ok_next;
        rd_slot_reg  <= rd_slot_next;
        o_kind_reg   <= o_kind_next;
        o_status_reg <= o_status_next;
        o_slot_reg   <= o_slot_next;
        o_entry_reg  <= o_entry_next;
        o_sbyte_reg  <= o_sbyte_next;
        o_count_reg  <= o_count_next;
        o_frames_reg <= o_frames_next;
    end

    assign rsp.valid         = ov_reg;
    assign rsp.result_kind   = o_kind_reg;
    assign rsp.frame_status  = o_status_reg;
    assign rsp.slot_index    = o_slot_reg;
    assign rsp.bssid         = o_entry_reg.bssid;
    assign rsp.channel       = o_entry_reg.channel;
    assign rsp.rssi          = o_entry_reg.rssi;
    assign rsp.security      = o_entry_reg.security;
    assign rsp.ssid_length   = o_entry_reg.ssid_length;
    assign rsp.ssid_byte     = o_sbyte_reg;
    assign rsp.network_count = o_count_reg;
    assign rsp.frame_count   = o_frames_reg;

`include "beacon_parser_network_table_assert.svh"

    // table never holds more than its capacity
    `BPNT_ASSERT_SAME(a_used_cap, clk, rst_n, 1'b1, used_reg <= (SLOT_W+1)'(TABLE_ENTRIES))
    // the search token only reaches the chain end while searching
    `BPNT_ASSERT_SAME(a_tok_search, clk, rst_n, tok[TABLE_ENTRIES].valid,
                      state_reg == S_SEARCH)
    // a last byte always leads into the verdict step
    `BPNT_ASSERT_NEXT(a_last_finish, clk, rst_n,
                      accept && req.opcode == OP_BYTE && req.last_byte,
                      state_reg == S_FINISH)
    // request side is closed outside idle
    `BPNT_ASSERT_SAME(a_ready_idle, clk, rst_n, req.ready, state_reg == S_IDLE)

endmodule
